### sv/gbbd_pkg.sv
// Shared types, codes and the CRC byte update for the block deframer.
`timescale 1ns / 1ps

package gbbd_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] HEADER_BYTES = 16'd8;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_BODY    = 3'd3,
    PH_VERDICT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LENGTH  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/gnss_binary_block_deframer.sv
// Sync / CRC / ID / length block deframer, one received byte per transfer.
// Results are registered: a result appears on the master side in the cycle after its byte.
// Throughput: one byte per cycle unless m_tready stalls the output; the CRC byte update,
// header compare and counters all sit between the state and output registers.
// Reset (rst, synchronous, active high): hunting the first sync byte, counters and
// CRC cleared, registers back to sync 0x24 / 0x40 and length limit 65535.
`timescale 1ns / 1ps

module gnss_binary_block_deframer import gbbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] payload_byte, [20:8] block_number, [23:21] block_revision,
  // [39:24] block_length, [55:40] good_blocks, [71:56] crc_failures
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] max_block_length;

  // deframer state
  phase_t      phase, phase_next;
  logic [2:0]  header_position, header_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] expected_crc, expected_crc_next;
  logic [15:0] id_word, id_word_next;
  logic [15:0] length_word, length_word_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] good_count, good_count_next;
  logic [15:0] crc_error_count, crc_error_count_next;

  logic        in_fire;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic        len_bad;
  logic        len_header_only;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_payload;

  assign cfg_ready = 1'b1;
  // output register frees up in the same cycle it is drained
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign b         = s_tdata;

  assign crc_upd         = crc_byte(running_crc, b);
  assign len_full        = {b, length_word[7:0]};
  assign len_bad         = (len_full < HEADER_BYTES) || (len_full > max_block_length);
  assign len_header_only = (len_full == HEADER_BYTES);

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT2: begin
        phase_next = (b == sync_second) ? PH_HEADER : PH_HUNT1;
      end
      PH_HEADER: begin
        case (header_position)
          3'd0, 3'd1, 3'd2, 3'd3, 3'd4: phase_next = PH_HEADER;
          3'd5: begin
            if (len_bad || len_header_only) begin
              phase_next = PH_HUNT1;
            end else begin
              phase_next = PH_BODY;
            end
          end
          default: phase_next = PH_HUNT1;
        endcase
      end
      PH_BODY: begin
        phase_next = (bytes_remaining == 16'd1) ? PH_VERDICT : PH_BODY;
      end
      // verdict byte doubles as a possible first sync byte
      default: begin
        phase_next = (b == sync_first) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    logic [15:0] crc_cmp;
    logic        do_verdict;
    header_position_next = header_position;
    running_crc_next     = running_crc;
    expected_crc_next    = expected_crc;
    id_word_next         = id_word;
    length_word_next     = length_word;
    bytes_remaining_next = bytes_remaining;
    good_count_next      = good_count;
    crc_error_count_next = crc_error_count;
    res_valid            = 1'b0;
    res_kind             = KIND_PAYLOAD;
    res_payload          = 8'h00;
    crc_cmp              = running_crc;
    do_verdict           = 1'b0;

    case (phase)
      PH_HUNT2: begin
        if (b == sync_second) begin
          header_position_next = 3'd0;
          running_crc_next     = 16'h0000;
        end
      end
      PH_HEADER: begin
        case (header_position)
          3'd0: expected_crc_next = {8'h00, b};
          3'd1: expected_crc_next = {b, expected_crc[7:0]};
          3'd2: begin
            id_word_next     = {8'h00, b};
            running_crc_next = crc_upd;
          end
          3'd3: begin
            id_word_next     = {b, id_word[7:0]};
            running_crc_next = crc_upd;
          end
          3'd4: begin
            length_word_next = {8'h00, b};
            running_crc_next = crc_upd;
          end
          3'd5: begin
            length_word_next = len_full;
            running_crc_next = crc_upd;
            if (len_bad) begin
              res_valid = 1'b1;
              res_kind  = KIND_BAD_LEN;
            end else if (len_header_only) begin
              // header-only block: verdict right on the last length byte
              crc_cmp    = crc_upd;
              do_verdict = 1'b1;
            end else begin
              bytes_remaining_next = len_full - HEADER_BYTES;
            end
          end
          default: ;
        endcase
        if (header_position < 3'd5) begin
          header_position_next = header_position + 3'd1;
        end
      end
      PH_BODY: begin
        running_crc_next     = crc_upd;
        bytes_remaining_next = bytes_remaining - 16'd1;
        res_valid            = 1'b1;
        res_kind             = KIND_PAYLOAD;
        res_payload          = b;
      end
      PH_VERDICT: begin
        do_verdict = 1'b1;
      end
      default: ;
    endcase

    if (do_verdict) begin
      res_valid = 1'b1;
      if (crc_cmp == expected_crc) begin
        res_kind = KIND_GOOD;
        if (good_count != 16'hFFFF) begin
          good_count_next = good_count + 16'd1;
        end
      end else begin
        res_kind = KIND_CRC_ERR;
        if (crc_error_count != 16'hFFFF) begin
          crc_error_count_next = crc_error_count + 16'd1;
        end
      end
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first       <= 8'd36;
      sync_second      <= 8'd64;
      max_block_length <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first       <= cfg_data[7:0];
        REG_SYNC_SECOND: sync_second      <= cfg_data[7:0];
        REG_MAX_LENGTH:  max_block_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // state registers, advance once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      header_position <= 3'd0;
      running_crc     <= 16'h0000;
      expected_crc    <= 16'h0000;
      id_word         <= 16'h0000;
      length_word     <= 16'h0000;
      bytes_remaining <= 16'h0000;
      good_count      <= 16'h0000;
      crc_error_count <= 16'h0000;
    end else if (in_fire) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      running_crc     <= running_crc_next;
      expected_crc    <= expected_crc_next;
      id_word         <= id_word_next;
      length_word     <= length_word_next;
      bytes_remaining <= bytes_remaining_next;
      good_count      <= good_count_next;
      crc_error_count <= crc_error_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tuser <= res_kind;
      m_tdata <= {crc_error_count_next, good_count_next, length_word_next,
                  id_word_next[15:13], id_word_next[12:0], res_payload};
    end
  end

endmodule

### dv/tb_gnss_binary_block_deframer.sv
// Self-checking testbench for the block deframer: byte stream in, payload and verdicts out.
`timescale 1ns / 1ps

module tb_gnss_binary_block_deframer;
  import gbbd_pkg::*;

  // One result transfer as the block should present it.
  typedef struct {
    kind_t       kind;
    logic [7:0]  payload;
    logic [12:0] number;
    logic [2:0]  revision;
    logic [15:0] length;
    logic [15:0] good;
    logic [15:0] fails;
  } block_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;    // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;              // [7:0] payload, [20:8] number, [23:21] revision,
                                     // [39:24] length, [55:40] good, [71:56] crc failures
  logic [1:0]  m_tuser;              // [1:0] kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SYNC_FIRST;
  logic [15:0] cfg_data  = 16'h0000;

  // Bytes waiting for the driver and results waiting for the monitor.
  logic [7:0]    byte_backlog [$];
  block_result_t results_due  [$];
  block_result_t want;
  int            bytes_queued  = 0;
  int            mismatches    = 0;
  int            idle_pct      = 38;
  bit            hold_mid_block = 1'b0;

  // Predictor copy of the configuration (reset values).
  logic [7:0]  sync_a    = 8'h24;
  logic [7:0]  sync_b    = 8'h40;
  logic [15:0] len_limit = 16'hFFFF;

  // Predictor copy of the deframer state (reset values).
  phase_t      ph        = PH_HUNT1;
  logic [2:0]  hdr_pos   = 3'd0;
  logic [15:0] crc_acc   = 16'h0000;
  logic [15:0] crc_want  = 16'h0000;
  logic [15:0] blk_id    = 16'h0000;
  logic [15:0] blk_len   = 16'h0000;
  logic [15:0] body_left = 16'h0000;
  logic [15:0] good_cnt  = 16'h0000;
  logic [15:0] fail_cnt  = 16'h0000;

  gnss_binary_block_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the run hangs.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // CCITT, poly 0x1021, MSB first, bit-serial form.
  function automatic logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void post_result(input kind_t k, input logic [7:0] p);
    block_result_t r;
    r.kind     = k;
    r.payload  = p;
    r.number   = blk_id[12:0];
    r.revision = blk_id[15:13];
    r.length   = blk_len;
    r.good     = good_cnt;
    r.fails    = fail_cnt;
    results_due.insert(results_due.size(), r);
  endfunction

  // Verdict on the finished block; counters stick at all ones.
  function automatic void close_block();
    if (crc_acc == crc_want) begin
      if (good_cnt != 16'hFFFF) good_cnt = good_cnt + 16'd1;
      post_result(KIND_GOOD, 8'h00);
    end else begin
      if (fail_cnt != 16'hFFFF) fail_cnt = fail_cnt + 16'd1;
      post_result(KIND_CRC_ERR, 8'h00);
    end
  endfunction

  // Advance the predicted deframer by one accepted byte.
  function automatic void deframe_byte(input logic [7:0] b);
    case (ph)
      PH_HUNT2: begin
        // a wrong second byte drops back without a second look at it
        if (b == sync_b) begin
          ph      = PH_HEADER;
          hdr_pos = 3'd0;
          crc_acc = 16'h0000;
        end else begin
          ph = PH_HUNT1;
        end
      end
      PH_HEADER: begin
        case (hdr_pos)
          3'd0: crc_want = {8'h00, b};
          3'd1: crc_want[15:8] = b;
          3'd2: begin
            blk_id  = {8'h00, b};
            crc_acc = ccitt_step(crc_acc, b);
          end
          3'd3: begin
            blk_id[15:8] = b;
            crc_acc      = ccitt_step(crc_acc, b);
          end
          3'd4: begin
            blk_len = {8'h00, b};
            crc_acc = ccitt_step(crc_acc, b);
          end
          3'd5: begin
            blk_len[15:8] = b;
            crc_acc       = ccitt_step(crc_acc, b);
            if (blk_len < HEADER_BYTES || blk_len > len_limit) begin
              post_result(KIND_BAD_LEN, 8'h00);
              ph = PH_HUNT1;
            end else if (blk_len == HEADER_BYTES) begin
              // header-only block: verdict right on the last length byte
              close_block();
              ph = PH_HUNT1;
            end else begin
              body_left = blk_len - HEADER_BYTES;
              ph        = PH_BODY;
            end
          end
          default: ph = PH_HUNT1;
        endcase
        if (ph == PH_HEADER) hdr_pos = hdr_pos + 3'd1;
      end
      PH_BODY: begin
        crc_acc = ccitt_step(crc_acc, b);
        post_result(KIND_PAYLOAD, b);
        body_left = body_left - 16'd1;
        if (body_left == 16'h0000) ph = PH_VERDICT;
      end
      PH_VERDICT: begin
        // the verdict byte also counts as a candidate first sync byte
        close_block();
        ph = (b == sync_a) ? PH_HUNT2 : PH_HUNT1;
      end
      default: ph = (b == sync_a) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
  endtask

  // Driver: on each transfer advance the predictor, then offer the next byte or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d data %h", m_tuser, m_tdata));
        end else begin
          want = results_due.pop_front();
          if (m_tuser != want.kind || m_tdata[7:0] != want.payload ||
              m_tdata[20:8] != want.number || m_tdata[23:21] != want.revision ||
              m_tdata[39:24] != want.length || m_tdata[55:40] != want.good ||
              m_tdata[71:56] != want.fails)
            note_mismatch($sformatf({"exp kind %0d pay %h num %0d rev %0d len %0d ",
                                     "good %0d fail %0d / got kind %0d pay %h num %0d ",
                                     "rev %0d len %0d good %0d fail %0d"},
                                    want.kind, want.payload, want.number, want.revision,
                                    want.length, want.good, want.fails, m_tuser,
                                    m_tdata[7:0], m_tdata[20:8], m_tdata[23:21],
                                    m_tdata[39:24], m_tdata[55:40], m_tdata[71:56]));
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Stimulus side runs on falling edges so it never races the clocked driver.
  task automatic put_byte(input logic [7:0] b);
    while (byte_backlog.size() >= 512) @(negedge clk);
    byte_backlog.insert(byte_backlog.size(), b);
    bytes_queued++;
  endtask

  // Wait until every byte has gone in and every predicted result has come out.
  task automatic settle();
    do @(negedge clk); while (byte_backlog.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  sync_a    = val[7:0];
      REG_SYNC_SECOND: sync_b    = val[7:0];
      REG_MAX_LENGTH:  len_limit = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Sync pair, CRC, ID, length, then body_n random body bytes. A bad CRC is
  // made by flipping a nonzero pattern into the correct one.
  task automatic push_block(input logic [15:0] id, input logic [15:0] len,
                            input int body_n, input bit crc_ok);
    logic [7:0]  body [$];
    logic [7:0]  rb;
    logic [15:0] c;
    logic [15:0] flip;
    c = ccitt_step(16'h0000, id[7:0]);
    c = ccitt_step(c, id[15:8]);
    c = ccitt_step(c, len[7:0]);
    c = ccitt_step(c, len[15:8]);
    for (int i = 0; i < body_n; i++) begin
      rb = 8'($urandom_range(255));
      body.insert(body.size(), rb);
      c = ccitt_step(c, rb);
    end
    if (!crc_ok) begin
      flip = 16'($urandom_range(65535, 1));
      c    = c ^ flip;
    end
    put_byte(sync_a);
    put_byte(sync_b);
    put_byte(c[7:0]);
    put_byte(c[15:8]);
    put_byte(id[7:0]);
    put_byte(id[15:8]);
    put_byte(len[7:0]);
    put_byte(len[15:8]);
    // sender holds off mid-block until the block has caught up
    if (hold_mid_block) begin
      hold_mid_block = 1'b0;
      settle();
    end
    foreach (body[i]) put_byte(body[i]);
  endtask

  // Mostly well-formed blocks with random content; the rest is line noise,
  // headers cut short and blocks with out-of-range lengths.
  task automatic random_traffic(input int budget);
    int          stop_at;
    int          pick;
    int          body_n;
    int          n;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  rb;
    stop_at = bytes_queued + budget;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(99);
      id   = 16'($urandom_range(65535));
      if (pick < 8) begin
        n = $urandom_range(5, 1);
        repeat (n) begin
          if ($urandom_range(3) == 0) rb = sync_a;
          else rb = 8'($urandom_range(255));
          put_byte(rb);
        end
      end else if (pick < 14) begin
        put_byte(sync_a);
        put_byte(sync_b);
        n = $urandom_range(5);
        repeat (n) begin
          rb = 8'($urandom_range(255));
          put_byte(rb);
        end
      end else if (pick < 24) begin
        if (len_limit != 16'hFFFF && $urandom_range(1) == 1)
          len = 16'($urandom_range(65535, len_limit + 1));
        else
          len = 16'($urandom_range(7));
        push_block(id, len, 0, 1'b1);
      end else begin
        body_n = ($urandom_range(19) == 0) ? $urandom_range(120) : $urandom_range(20);
        if (len_limit >= HEADER_BYTES && body_n > len_limit - HEADER_BYTES)
          body_n = int'(len_limit - HEADER_BYTES);
        len = 16'(body_n + 8);
        push_block(id, len, body_n, $urandom_range(3) != 0);
      end
    end
  endtask

  initial begin
    logic [15:0] rv;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: a broken sync pair, a header-only block with
    // an all-ones ID, a bad-CRC block whose verdict byte starts the next
    // block, and that next block with a length below the header size.
    put_byte(8'h24);
    put_byte(8'h24);
    put_byte(8'h40);
    push_block(16'hFFFF, 16'd8, 0, 1'b1);
    push_block(16'h0000, 16'd10, 2, 1'b0);
    push_block(16'h1234, 16'd7, 0, 1'b1);
    put_byte(8'hFF);
    settle();

    // Sync extremes, tightest legal limit; upper data bits must be ignored.
    write_reg(REG_SYNC_FIRST, 16'hA500);
    write_reg(REG_SYNC_SECOND, 16'h00FF);
    write_reg(REG_MAX_LENGTH, 16'd8);
    random_traffic(200);
    settle();

    // Swapped sync extremes; limit under the header size rejects every block.
    write_reg(REG_SYNC_FIRST, 16'h00FF);
    write_reg(REG_SYNC_SECOND, 16'h5A00);
    write_reg(REG_MAX_LENGTH, 16'd5);
    random_traffic(100);
    settle();

    // Random sync pair, moderate limit, plus a write to the unused index.
    rv = 16'($urandom_range(65535));
    write_reg(REG_SYNC_FIRST, rv);
    rv = 16'($urandom_range(65535));
    write_reg(REG_SYNC_SECOND, rv);
    write_reg(REG_MAX_LENGTH, 16'd40);
    rv = 16'($urandom_range(65535));
    write_reg(REG_UNUSED, rv);
    random_traffic(300);
    settle();

    // Random sync pair, full limit; one mid-block pause by the sender.
    rv = 16'($urandom_range(65535));
    write_reg(REG_SYNC_FIRST, rv);
    rv = 16'($urandom_range(65535));
    write_reg(REG_SYNC_SECOND, rv);
    write_reg(REG_MAX_LENGTH, 16'hFFFF);
    hold_mid_block = 1'b1;
    random_traffic(600);
    settle();

    // Back to reset settings with no idling on either side.
    write_reg(REG_SYNC_FIRST, 16'h0024);
    write_reg(REG_SYNC_SECOND, 16'h0040);
    write_reg(REG_MAX_LENGTH, 16'hFFFF);
    idle_pct = 0;
    random_traffic(300);
    settle();
    idle_pct = 38;

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gbbd_pkg.sv
sv/gnss_binary_block_deframer.sv
dv/tb_gnss_binary_block_deframer.sv
